### rtl/rsfu_pkg.sv
package rsfu_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = 56;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MARKERS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WANT    = 3'd4;

    // pixel formats; codes above F_RAW12 behave as F_RAW8
    localparam logic [2:0] F_RAW8  = 3'd0;
    localparam logic [2:0] F_RAW10 = 3'd1;
    localparam logic [2:0] F_UNP10 = 3'd2;
    localparam logic [2:0] F_UNP12 = 3'd3;
    localparam logic [2:0] F_RAW12 = 3'd4;

    typedef enum logic [2:0] {
        K_PIXEL  = 3'd0,
        K_FRAME  = 3'd1,
        K_ALL    = 3'd2,
        K_NOHDR  = 3'd3,
        K_BADFTR = 3'd4,
        K_TRUNC  = 3'd5
    } t_kind;

    // Results caused by one byte: up to four pixels, then at most one event
    typedef struct packed {
        logic             has_pix;
        logic [3:0][15:0] pix;
        logic [11:0]      row;
        logic [11:0]      col;
        logic [15:0]      pix_frame;
        logic             has_evt;
        t_kind            evt_kind;
        logic [15:0]      evt_frame;
    } t_job;

endpackage

### rtl/rsfu_front.sv
module rsfu_front #(
    parameter int MAX_ROWS     = 4096,
    parameter int MAX_COLS     = 4096,
    parameter int HEADER_BYTES = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rsfu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rsfu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_byte,
    input  logic                           i_end,
    output logic                           o_push,
    output rsfu_pkg::t_job                 o_job,
    input  logic                           i_full
);
    import rsfu_pkg::*;

    localparam int RW   = $clog2(MAX_ROWS + 1);
    localparam int CW   = $clog2(MAX_COLS + 1);
    localparam int PW   = $clog2(HEADER_BYTES + 1);
    localparam int MW0  = (RW > CW) ? RW : CW;
    localparam int CMPW = ((MW0 > 13) ? MW0 : 13) + 1;
    localparam bit SKIP_ON = (HEADER_BYTES > 8);

    typedef enum logic [2:0] {
        M_START, M_SEARCH, M_SKIP, M_PIXEL, M_FOOTER
    } t_mode;

    function automatic logic [1:0] mark_class(input logic [2:0] fmt);
        logic [1:0] c;
        unique case (fmt) inside
            F_RAW8:           c = 2'd0;
            F_RAW10, F_UNP10: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] group_size(input logic [2:0] fmt);
        logic [3:0] s;
        unique case (fmt) inside
            F_RAW10:          s = 4'd5;
            F_UNP10, F_UNP12: s = 4'd8;
            F_RAW12:          s = 4'd6;
            default:          s = 4'd4;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] marker_byte(input logic [1:0] cls, input logic [2:0] idx,
                                               input logic footer);
        logic [7:0] v;
        unique case (cls)
            2'd0:    v = (idx == 3'd7) ? 8'hf5 : (footer ? 8'hf1 : 8'hf0);
            2'd1:    v = (idx == 3'd7) ? 8'hf6 : (footer ? 8'hf1 : 8'hf0);
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [3:0][15:0] unpack(input logic [2:0] fmt,
                                                input logic [7:0][7:0] g);
        logic [3:0][15:0] p;
        unique case (fmt) inside
            F_RAW10: begin
                p[0] = {6'd0, g[1][1:0], g[0]};
                p[1] = {6'd0, g[2][3:0], g[1][7:2]};
                p[2] = {6'd0, g[3][5:0], g[2][7:4]};
                p[3] = {6'd0, g[4], g[3][7:6]};
            end
            F_UNP10, F_UNP12: begin
                for (int i = 0; i < 4; i++) begin
                    p[i] = {g[2*i+1], g[2*i]};
                end
            end
            F_RAW12: begin
                p[0] = {4'd0, g[0], g[2][3:0]};
                p[1] = {4'd0, g[1], g[2][7:4]};
                p[2] = {4'd0, g[3], g[5][3:0]};
                p[3] = {4'd0, g[4], g[5][7:4]};
            end
            default: begin
                for (int i = 0; i < 4; i++) begin
                    p[i] = {8'd0, g[i]};
                end
            end
        endcase
        return p;
    endfunction

    // configuration
    logic [2:0]  r_fmt;
    logic        r_mark;
    logic [12:0] r_rows;
    logic [12:0] r_cols;
    logic [15:0] r_want;

    // parser state
    t_mode          r_mode,    n_mode;
    logic [PW-1:0]  r_phase,   n_phase;
    logic [7:0][7:0] r_gb,     n_gb;
    logic           r_mok,     n_mok;
    logic [RW-1:0]  r_row,     n_row;
    logic [CW-1:0]  r_col,     n_col;
    logic [15:0]    r_frame,   n_frame;
    logic           r_stopped, n_stopped;

    logic [2:0]      fmt;
    logic [1:0]      cls;
    logic [3:0]      gsize;
    logic [CMPW-1:0] cols_eff;
    logic [CMPW-1:0] rows_eff;
    logic [16:0]     want_eff;
    logic [CMPW-1:0] row_ext;
    logic [CMPW-1:0] col_ext;
    logic [CMPW-1:0] col_sum;
    logic [CMPW-1:0] row_sum;
    logic [PW:0]     skip_sum;
    logic            acc;
    logic            do_finish;
    t_job            job;

    assign fmt      = (r_fmt > F_RAW12) ? F_RAW8 : r_fmt;
    assign cls      = mark_class(fmt);
    assign gsize    = group_size(fmt);
    assign cols_eff = (CMPW'(r_cols) > CMPW'(MAX_COLS)) ? CMPW'(MAX_COLS) : CMPW'(r_cols);
    assign rows_eff = (CMPW'(r_rows) > CMPW'(MAX_ROWS)) ? CMPW'(MAX_ROWS) : CMPW'(r_rows);
    assign want_eff = (r_want == 16'd0) ? 17'd1 : {1'b0, r_want};
    assign o_ready  = !i_full;
    assign acc      = i_valid && o_ready;

    always_comb begin
        n_mode    = r_mode;
        n_phase   = r_phase;
        n_gb      = r_gb;
        n_mok     = r_mok;
        n_row     = r_row;
        n_col     = r_col;
        n_frame   = r_frame;
        n_stopped = r_stopped;
        job       = '0;
        do_finish = 1'b0;
        row_ext   = '0;
        col_ext   = '0;
        col_sum   = '0;
        row_sum   = '0;
        skip_sum  = '0;

        if (acc && !r_stopped) begin
            if (r_mode == M_START) begin
                n_mode  = r_mark ? M_SEARCH : M_PIXEL;
                n_phase = '0;
                n_mok   = 1'b1;
                n_row   = '0;
                n_col   = '0;
            end
            row_ext       = CMPW'(n_row);
            col_ext       = CMPW'(n_col);
            job.row       = row_ext[11:0];
            job.col       = col_ext[11:0];
            job.pix_frame = r_frame;

            unique case (n_mode)
                M_SEARCH, M_FOOTER: begin
                    if (i_byte != marker_byte(cls, n_phase[2:0], n_mode == M_FOOTER)) begin
                        n_mok = 1'b0;
                    end
                    n_gb[n_phase[2:0]] = i_byte;
                    if (n_phase[2:0] == 3'd7) begin
                        n_phase = '0;
                        if (n_mode == M_SEARCH) begin
                            if (n_mok) begin
                                n_mode = SKIP_ON ? M_SKIP : M_PIXEL;
                            end
                        end else if (n_mok) begin
                            do_finish = 1'b1;
                        end else begin
                            job.has_evt   = 1'b1;
                            job.evt_kind  = K_BADFTR;
                            job.evt_frame = r_frame;
                            n_stopped     = 1'b1;
                        end
                        n_mok = 1'b1;
                    end else begin
                        n_phase = n_phase + 1'b1;
                    end
                end
                M_SKIP: begin
                    skip_sum = (PW+1)'(n_phase) + (PW+1)'(9);
                    if (skip_sum >= (PW+1)'(HEADER_BYTES)) begin
                        n_phase = '0;
                        n_mode  = M_PIXEL;
                    end else begin
                        n_phase = n_phase + 1'b1;
                    end
                end
                M_PIXEL: begin
                    n_gb[n_phase[2:0]] = i_byte;
                    if (({1'b0, n_phase[2:0]} + 4'd1) >= gsize) begin
                        n_phase     = '0;
                        job.has_pix = 1'b1;
                        job.pix     = unpack(fmt, n_gb);
                        col_sum     = col_ext + CMPW'(4);
                        if (col_sum >= cols_eff) begin
                            n_col   = '0;
                            row_sum = row_ext + CMPW'(1);
                            n_row   = RW'(row_sum);
                            if (row_sum >= rows_eff) begin
                                if (r_mark) begin
                                    n_mode = M_FOOTER;
                                    n_mok  = 1'b1;
                                end else begin
                                    do_finish = 1'b1;
                                end
                            end
                        end else begin
                            n_col = CW'(col_sum);
                        end
                    end else begin
                        n_phase = n_phase + 1'b1;
                    end
                end
                default: begin
                    n_mode = M_START;
                end
            endcase

            if (do_finish) begin
                job.has_evt   = 1'b1;
                job.evt_frame = r_frame;
                if (({1'b0, r_frame} + 17'd1) >= want_eff) begin
                    job.evt_kind = K_ALL;
                    n_stopped    = 1'b1;
                end else begin
                    job.evt_kind = K_FRAME;
                    n_frame      = r_frame + 16'd1;
                    n_mode       = M_START;
                end
            end

            // end of data replaces a frame-done event
            if (i_end && !n_stopped) begin
                job.has_evt   = 1'b1;
                job.evt_kind  = (n_mode == M_SEARCH || (n_mode == M_START && r_mark))
                                ? K_NOHDR : K_TRUNC;
                job.evt_frame = n_frame;
                n_stopped     = 1'b1;
            end
        end
    end

    assign o_job  = job;
    assign o_push = acc && (job.has_pix || job.has_evt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt     <= F_RAW8;
            r_mark    <= 1'b1;
            r_rows    <= 13'd2488;
            r_cols    <= 13'd3312;
            r_want    <= 16'd1;
            r_mode    <= M_START;
            r_phase   <= '0;
            r_gb      <= '0;
            r_mok     <= 1'b1;
            r_row     <= '0;
            r_col     <= '0;
            r_frame   <= '0;
            r_stopped <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_phase   <= n_phase;
            r_gb      <= n_gb;
            r_mok     <= n_mok;
            r_row     <= n_row;
            r_col     <= n_col;
            r_frame   <= n_frame;
            r_stopped <= n_stopped;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_FORMAT:  r_fmt  <= i_cfg_data[2:0];
                    REG_MARKERS: r_mark <= i_cfg_data[0];
                    REG_ROWS:    r_rows <= i_cfg_data[12:0];
                    REG_COLS:    r_cols <= i_cfg_data[12:0];
                    REG_WANT:    r_want <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    a_stop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("parser left the stopped state without reset");

endmodule

### rtl/rsfu_queue.sv
module rsfu_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rsfu_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output rsfu_pkg::t_job o_head,
    output logic           o_empty
);
    import rsfu_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("request pushed into full queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

### rtl/rsfu_back.sv
module rsfu_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rsfu_pkg::t_job                 i_head,
    input  logic                           i_empty,
    output logic                           o_pop,
    output logic                           o_tvalid,
    input  logic                           i_tready,
    output logic [rsfu_pkg::OUT_DATA_W-1:0] o_tdata,
    output logic [2:0]                     o_tuser,
    output logic                           o_tlast
);
    import rsfu_pkg::*;

    localparam logic [2:0] IDX_EVT  = 3'd4;
    localparam logic [2:0] IDX_PIX3 = 3'd3;

    logic                  r_valid;
    logic [2:0]            r_idx;
    logic [OUT_DATA_W-1:0] r_data;
    t_kind                 r_kind;
    logic                  r_last;

    logic                  load;
    logic [2:0]            cur;
    logic [2:0]            last_idx;
    logic [OUT_DATA_W-1:0] n_data;
    t_kind                 n_kind;

    always_comb begin
        cur      = (r_idx == 3'd0 && !i_head.has_pix) ? IDX_EVT : r_idx;
        last_idx = i_head.has_evt ? IDX_EVT : IDX_PIX3;
        load     = !i_empty && (!r_valid || i_tready);
        o_pop    = load && (cur == last_idx);
        if (cur == IDX_EVT) begin
            n_kind = i_head.evt_kind;
            n_data = {i_head.evt_frame, 40'd0};
        end else begin
            n_kind = K_PIXEL;
            n_data = {i_head.pix_frame, i_head.pix[cur[1:0]],
                      i_head.col + {10'd0, cur[1:0]}, i_head.row};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= o_pop ? 3'd0 : cur + 3'd1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_data;
            r_kind <= n_kind;
            r_last <= o_pop;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tuser  = r_kind;
    assign o_tlast  = r_last;

    a_evt_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && o_tuser != K_PIXEL) |-> o_tlast)
        else $error("event result not last of its byte");

    a_evt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && o_tuser != K_PIXEL) |-> (o_tdata[39:0] == 40'd0))
        else $error("event result carries pixel fields");

endmodule

### rtl/raw_sensor_frame_unpacker.sv
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata[7:0] data_byte, tlast end_of_data
// m_axis    out  m_axis_tvalid/tready        tdata row/col/value/frame, tuser kind,
//                                            tlast run_last
// cfg       in   i_cfg_we                    i_cfg_idx register, i_cfg_data value
//
// The front parser takes one byte per cycle while the queue has room; results leave one per
// cycle from the output register while m_axis_tready is high, so a byte yielding k results
// holds the output until all k have left. A four-entry request queue between parser and
// emitter absorbs bursts; the input stalls only when it is full. A byte's first result
// passes through the queue and then the output register. Synchronous active-low reset restores
// configuration, parser, queue and output control; queue and output data need no clearing pass.
module raw_sensor_frame_unpacker #(
    parameter int MAX_ROWS     = 4096,
    parameter int MAX_COLS     = 4096,
    parameter int HEADER_BYTES = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rsfu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rsfu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [11:0] pixel_row, [23:12] pixel_col, [39:24] pixel_value, [55:40] frame_number
    output logic [rsfu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [2:0]                      m_axis_tuser,  // [2:0] kind
    output logic                            m_axis_tlast
);
    import rsfu_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job front_job;
    t_job head_job;

    rsfu_front #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLS     (MAX_COLS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_byte     (s_axis_tdata),
        .i_end      (s_axis_tlast),
        .o_push     (push),
        .o_job      (front_job),
        .i_full     (full)
    );

    rsfu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_empty (empty)
    );

    rsfu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_job),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

### tb/tb_raw_sensor_frame_unpacker.sv
module tb_raw_sensor_frame_unpacker;
    timeunit 1ns;
    timeprecision 1ps;

    import rsfu_pkg::*;

    localparam int MAX_ROWS     = 4096;
    localparam int MAX_COLS     = 4096;
    localparam int HEADER_BYTES = 32;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int IDLE_PCT     = 27;
    localparam int DRAIN_CYCLES = 8;

    // marker bytes
    localparam logic [7:0] HDR_FILL   = 8'hF0;
    localparam logic [7:0] FTR_FILL   = 8'hF1;
    localparam logic [7:0] TAIL_RAW8  = 8'hF5;
    localparam logic [7:0] TAIL_RAW10 = 8'hF6;

    // byte content styles
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ONES   = 1;
    localparam int FILL_ZEROS  = 2;

    // terminal cases of the run
    localparam int END_ALL_DONE   = 0;
    localparam int END_BAD_FOOTER = 1;
    localparam int END_CUT_ANY    = 2;
    localparam int END_CUT_SEARCH = 3;
    localparam int END_CUT_LAST   = 4;

    typedef enum int {ST_START, ST_SEARCH, ST_SKIP, ST_PIXEL, ST_FOOTER} t_parse_state;

    typedef struct packed {
        t_kind       kind;
        logic [11:0] row;
        logic [11:0] col;
        logic [15:0] value;
        logic [15:0] frame;
        logic        last;
    } t_pix_event;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_raw_byte;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [2:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    t_raw_byte  byte_backlog [$];
    t_pix_event due_results [$];

    int  cycle_count = 0;
    int  miss_count  = 0;
    int  byte_fill   = FILL_RANDOM;
    int  payload_count = 0;
    logic calm;

    // predictor copy of the registers
    int   cfg_format  = 0;
    logic cfg_markers = 1'b1;
    int   cfg_rows    = 2488;
    int   cfg_cols    = 3312;
    int   cfg_want    = 1;

    // predictor copy of the parser
    t_parse_state pmode  = ST_START;
    int           phase  = 0;
    logic [7:0]   grp [8] = '{default: 8'h00};
    logic         mark_ok = 1'b1;
    int           row_cnt = 0;
    int           col_cnt = 0;
    logic [15:0]  frm_cnt = '0;
    logic         halted  = 1'b0;

    t_pix_event step_res [6];
    int         step_n;

    raw_sensor_frame_unpacker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5ns i_clk = 1'b1;
        #5ns i_clk = 1'b0;
    end

    assign calm = (cycle_count >= 200) && (cycle_count < 500);

    function automatic int eff_format(input int f);
        return (f > F_RAW12) ? F_RAW8 : f;
    endfunction

    function automatic int group_len(input int f);
        case (f)
            F_RAW10:          return 5;
            F_UNP10, F_UNP12: return 8;
            F_RAW12:          return 6;
            default:          return 4;
        endcase
    endfunction

    function automatic logic [7:0] marker_byte(input bit footer, input int f, input int idx);
        logic [7:0] fill;
        fill = footer ? FTR_FILL : HDR_FILL;
        case (f)
            F_UNP12, F_RAW12: return 8'h00;
            F_RAW10, F_UNP10: return (idx < 7) ? fill : TAIL_RAW10;
            default:          return (idx < 7) ? fill : TAIL_RAW8;
        endcase
    endfunction

    function automatic void emit(input t_kind k, input int row, input int col,
                                 input logic [15:0] val);
        step_res[step_n].kind  = k;
        step_res[step_n].row   = 12'(row);
        step_res[step_n].col   = 12'(col);
        step_res[step_n].value = val;
        step_res[step_n].frame = frm_cnt;
        step_res[step_n].last  = 1'b0;
        step_n++;
    endfunction

    function automatic void close_frame();
        int want;
        want = (cfg_want == 0) ? 1 : cfg_want;
        if (int'(frm_cnt) + 1 >= want) begin
            emit(K_ALL, 0, 0, 16'h0);
            halted = 1'b1;
        end else begin
            emit(K_FRAME, 0, 0, 16'h0);
            frm_cnt = frm_cnt + 16'd1;
            pmode   = ST_START;
        end
    endfunction

    // Advance the parser copy by one byte and queue what it yields
    function automatic void unpack_step(input logic [7:0] b, input logic eod);
        int          fmt;
        int          cols;
        int          rows;
        int          i;
        logic [15:0] px [4];
        t_kind       err;
        step_n = 0;
        if (halted) return;
        fmt = eff_format(cfg_format);
        if (pmode == ST_START) begin
            pmode   = cfg_markers ? ST_SEARCH : ST_PIXEL;
            phase   = 0;
            mark_ok = 1'b1;
            row_cnt = 0;
            col_cnt = 0;
        end
        case (pmode)
            ST_SEARCH: begin
                if (b != marker_byte(1'b0, fmt, phase % 8)) mark_ok = 1'b0;
                grp[phase % 8] = b;
                phase++;
                if (phase >= 8) begin
                    phase = 0;
                    if (mark_ok) pmode = (HEADER_BYTES > 8) ? ST_SKIP : ST_PIXEL;
                    mark_ok = 1'b1;
                end
            end
            ST_SKIP: begin
                phase++;
                if (phase + 8 >= HEADER_BYTES) begin
                    phase = 0;
                    pmode = ST_PIXEL;
                end
            end
            ST_PIXEL: begin
                grp[phase % 8] = b;
                phase++;
                if (phase >= group_len(fmt)) begin
                    phase = 0;
                    case (fmt)
                        F_RAW10: begin
                            px[0] = 16'({grp[1][1:0], grp[0]});
                            px[1] = 16'({grp[2][3:0], grp[1][7:2]});
                            px[2] = 16'({grp[3][5:0], grp[2][7:4]});
                            px[3] = 16'({grp[4], grp[3][7:6]});
                        end
                        F_UNP10, F_UNP12: begin
                            for (i = 0; i < 4; i++) px[i] = {grp[2*i+1], grp[2*i]};
                        end
                        F_RAW12: begin
                            px[0] = 16'({grp[0], grp[2][3:0]});
                            px[1] = 16'({grp[1], grp[2][7:4]});
                            px[2] = 16'({grp[3], grp[5][3:0]});
                            px[3] = 16'({grp[4], grp[5][7:4]});
                        end
                        default: begin
                            for (i = 0; i < 4; i++) px[i] = {8'h00, grp[i]};
                        end
                    endcase
                    for (i = 0; i < 4; i++) emit(K_PIXEL, row_cnt, col_cnt + i, px[i]);
                    cols = (cfg_cols > MAX_COLS) ? MAX_COLS : cfg_cols;
                    rows = (cfg_rows > MAX_ROWS) ? MAX_ROWS : cfg_rows;
                    if (col_cnt + 4 >= cols) begin
                        col_cnt = 0;
                        row_cnt++;
                        if (row_cnt >= rows) begin
                            if (cfg_markers) begin
                                pmode   = ST_FOOTER;
                                mark_ok = 1'b1;
                            end else begin
                                close_frame();
                            end
                        end
                    end else begin
                        col_cnt += 4;
                    end
                end
            end
            ST_FOOTER: begin
                if (b != marker_byte(1'b1, fmt, phase % 8)) mark_ok = 1'b0;
                grp[phase % 8] = b;
                phase++;
                if (phase >= 8) begin
                    phase = 0;
                    if (mark_ok) begin
                        close_frame();
                    end else begin
                        emit(K_BADFTR, 0, 0, 16'h0);
                        halted = 1'b1;
                    end
                    mark_ok = 1'b1;
                end
            end
            default: pmode = ST_START;
        endcase
        if (eod && !halted) begin
            err = (pmode == ST_SEARCH || (pmode == ST_START && cfg_markers)) ? K_NOHDR
                                                                              : K_TRUNC;
            // the error takes the place of a frame-done on the same byte
            if (step_n > 0 && step_res[step_n-1].kind == K_FRAME) step_n--;
            emit(err, 0, 0, 16'h0);
            halted = 1'b1;
        end
        if (step_n > 0) step_res[step_n-1].last = 1'b1;
        for (i = 0; i < step_n; i++) due_results.push_back(step_res[i]);
    endfunction

    function automatic string describe(input t_pix_event r);
        return $sformatf("kind %0d row %0d col %0d value %h frame %0d last %0b",
                         r.kind, r.row, r.col, r.value, r.frame, r.last);
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("raw_sensor_frame_unpacker test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin : byte_driver
        t_raw_byte nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) unpack_step(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (byte_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt = byte_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.data;
                    s_axis_tlast  <= nxt.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_pix_event seen;
        t_pix_event want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            if (m_axis_tvalid && m_axis_tready) begin
                seen.kind  = t_kind'(m_axis_tuser);
                seen.row   = m_axis_tdata[11:0];
                seen.col   = m_axis_tdata[23:12];
                seen.value = m_axis_tdata[39:24];
                seen.frame = m_axis_tdata[55:40];
                seen.last  = m_axis_tlast;
                if (due_results.size() == 0) begin
                    if (miss_count < 10) $display("unexpected result: %s", describe(seen));
                    miss_count++;
                end else begin
                    want = due_results.pop_front();
                    if (seen !== want) begin
                        if (miss_count < 10) begin
                            $display("mismatch: expected %s", describe(want));
                            $display("          actual   %s", describe(seen));
                        end
                        miss_count++;
                    end
                end
            end
        end
    end

    task automatic write_reg(input int idx, input int val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_W'(idx);
        i_cfg_data <= CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_FORMAT:  cfg_format  = val & 'h7;
            REG_MARKERS: cfg_markers = val[0];
            REG_ROWS:    cfg_rows    = val & 'h1FFF;
            REG_COLS:    cfg_cols    = val & 'h1FFF;
            REG_WANT:    cfg_want    = val & 'hFFFF;
            default: ;
        endcase
    endtask

    // Hold until every request is taken and every result is back
    task automatic settle();
        while (byte_backlog.size() != 0 || s_axis_tvalid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_byte(input logic [7:0] b, input bit noise);
        t_raw_byte it;
        it.data = b;
        it.last = 1'b0;
        byte_backlog.push_back(it);
        if (!noise) payload_count++;
    endtask

    function automatic logic [7:0] pick_byte();
        case (byte_fill)
            FILL_ONES:  return 8'hFF;
            FILL_ZEROS: return 8'h00;
            default: begin
                case ($urandom_range(0, 9))
                    0:       return 8'h00;
                    1:       return 8'hFF;
                    default: return 8'($urandom_range(0, 255));
                endcase
            end
        endcase
    endfunction

    // Queue one frame at the current settings; may switch format between rows
    task automatic gen_frame(input int noise_groups, input bit broken_hdr,
                             input bit bad_footer, input bit allow_switch);
        int fmt;
        int g;
        int i;
        int r;
        int k;
        int cols;
        int rows;
        int gpr;
        fmt = eff_format(cfg_format);
        if (cfg_markers) begin
            for (g = 0; g < noise_groups; g++) begin
                k = $urandom_range(0, 7);
                for (i = 0; i < 8; i++) begin
                    if (broken_hdr && g == noise_groups - 1)
                        push_byte(marker_byte(1'b0, fmt, i) ^
                                  ((i == k) ? 8'($urandom_range(1, 255)) : 8'h00), 1'b1);
                    else
                        push_byte(8'($urandom_range(0, 255)), 1'b1);
                end
            end
            for (i = 0; i < 8; i++) push_byte(marker_byte(1'b0, fmt, i), 1'b0);
            for (i = 0; i < HEADER_BYTES - 8; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        cols = (cfg_cols > MAX_COLS) ? MAX_COLS : cfg_cols;
        rows = (cfg_rows > MAX_ROWS) ? MAX_ROWS : cfg_rows;
        gpr  = (cols == 0) ? 1 : (cols + 3) / 4;
        if (rows == 0) rows = 1;
        for (r = 0; r < rows; r++) begin
            if (allow_switch && r > 0 && $urandom_range(0, 3) == 0) begin
                settle();
                write_reg(REG_FORMAT, $urandom_range(0, 7));
            end
            fmt = eff_format(cfg_format);
            for (g = 0; g < gpr * group_len(fmt); g++) push_byte(pick_byte(), 1'b0);
        end
        if (cfg_markers) begin
            k = $urandom_range(0, 7);
            for (i = 0; i < 8; i++)
                push_byte(marker_byte(1'b1, fmt, i) ^
                          ((bad_footer && i == k) ? 8'($urandom_range(1, 255)) : 8'h00), 1'b0);
        end
    endtask

    task automatic random_config();
        int cols;
        write_reg(REG_FORMAT, $urandom_range(0, 7));
        write_reg(REG_MARKERS, $urandom_range(0, 1));
        write_reg(REG_ROWS, $urandom_range(0, 2));
        case ($urandom_range(0, 3))
            0:       cols = $urandom_range(0, 7);
            1:       cols = $urandom_range(9, 14);
            default: cols = 4 * $urandom_range(1, 2);
        endcase
        write_reg(REG_COLS, cols);
    endtask

    initial begin
        int f;
        int scenario;
        int noise;
        int cut;
        int target;
        int i;
        t_raw_byte it;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_FORMAT, F_RAW8);
        write_reg(REG_MARKERS, 1);
        write_reg(REG_ROWS, 1);
        write_reg(REG_COLS, 4);
        write_reg(REG_WANT, 65535);

        // short frames: broken header first, then every format and the unknown codes
        gen_frame(1, 1'b1, 1'b0, 1'b0);
        for (f = F_RAW10; f <= 7; f++) begin
            settle();
            write_reg(REG_FORMAT, f);
            // markers on for one format of the RAW10 family and one of the 12-bit family
            write_reg(REG_MARKERS, (f == F_RAW10 || f == F_UNP12) ? 1 : 0);
            write_reg(REG_ROWS, (f == F_UNP10 || f == F_RAW12) ? 2 : 1);
            write_reg(REG_COLS, 4);
            byte_fill = f % 3;
            gen_frame(0, 1'b0, 1'b0, 1'b1);
        end
        byte_fill = FILL_RANDOM;

        // no markers: ragged row width, zero rows, zero columns
        settle();
        write_reg(REG_FORMAT, F_RAW12);
        write_reg(REG_MARKERS, 0);
        write_reg(REG_ROWS, 0);
        write_reg(REG_COLS, 6);
        gen_frame(0, 1'b0, 1'b0, 1'b0);
        settle();
        write_reg(REG_COLS, 0);
        write_reg(REG_ROWS, 2);
        gen_frame(0, 1'b0, 1'b0, 1'b0);

        // random frames at random small sizes
        target = payload_count + 30;
        while (payload_count < target) begin
            settle();
            random_config();
            if ($urandom_range(0, 7) == 0) write_reg(REG_WANT, $urandom_range(500, 65535));
            gen_frame($urandom_range(0, 1), $urandom_range(0, 2) == 0, 1'b0, 1'b1);
        end

        // one way to stop the run
        settle();
        scenario = $urandom_range(END_ALL_DONE, END_CUT_LAST);
        random_config();
        if (scenario == END_BAD_FOOTER || scenario == END_CUT_SEARCH) write_reg(REG_MARKERS, 1);
        if (scenario == END_ALL_DONE) begin
            case ($urandom_range(0, 2))
                0:       write_reg(REG_WANT, 0);
                1:       write_reg(REG_WANT, 1);
                default: write_reg(REG_WANT, int'(frm_cnt) + 1);
            endcase
        end
        noise = $urandom_range(1, 2);
        gen_frame(noise, $urandom_range(0, 1), scenario == END_BAD_FOOTER, 1'b0);
        if (scenario >= END_CUT_ANY) begin
            case (scenario)
                END_CUT_SEARCH: cut = $urandom_range(0, noise * 8 + 6);
                END_CUT_LAST:   cut = byte_backlog.size() - 1;
                default:        cut = $urandom_range(0, byte_backlog.size() - 1);
            endcase
            while (byte_backlog.size() > cut + 1) void'(byte_backlog.pop_back());
            it = byte_backlog[cut];
            it.last = 1'b1;
            byte_backlog[cut] = it;
        end
        // once stopped, bytes must yield nothing
        for (i = 0; i < 6; i++) begin
            it.data = 8'($urandom_range(0, 255));
            it.last = 1'($urandom_range(0, 1));
            byte_backlog.push_back(it);
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (miss_count == 0 && due_results.size() == 0) begin
            $display("raw_sensor_frame_unpacker test passed");
        end else begin
            $display("raw_sensor_frame_unpacker test failed");
        end
        $finish;
    end

endmodule

### raw_sensor_frame_unpacker.f
rtl/rsfu_pkg.sv
rtl/rsfu_front.sv
rtl/rsfu_queue.sv
rtl/rsfu_back.sv
rtl/raw_sensor_frame_unpacker.sv
tb/tb_raw_sensor_frame_unpacker.sv
